### rtl/core/mini_aes_encrypt_defines.svh
// Assertion macros shared by the mini AES encryption core
`ifndef MINI_AES_ENCRYPT_DEFINES_SVH
`define MINI_AES_ENCRYPT_DEFINES_SVH

// Checked on every clock edge, off while reset is held
`define MAES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included
`define MAES_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### rtl/core/maes_pkg.sv
// Types, constants and round functions of the mini AES encryption core
`default_nettype none

package maes_pkg;

    localparam int BlkW = 16;
    localparam int NibW = 4;

    typedef logic [NibW-1:0] t_nib;
    typedef logic [BlkW-1:0] t_block;

    typedef struct packed {
        t_block rk0;
        t_block rk1;
        t_block rk2;
    } t_round_keys;

    localparam t_nib RCON1 = 4'h1;
    localparam t_nib RCON2 = 4'h2;
    // x^4 + x + 1 with the x^4 term dropped
    localparam t_nib GF_RED = 4'h3;

    localparam t_nib SBOX [16] = '{
        4'hE, 4'h4, 4'hD, 4'h1, 4'h2, 4'hF, 4'hB, 4'h8,
        4'h3, 4'hA, 4'h6, 4'hC, 4'h5, 4'h9, 4'h0, 4'h7
    };

    function automatic t_nib sub_nib(input t_nib x);
        return SBOX[x];
    endfunction

    function automatic t_nib gf_x2(input t_nib x);
        t_nib t;
        t = {x[2:0], 1'b0};
        if (x[3]) begin
            t = t ^ GF_RED;
        end
        return t;
    endfunction

    function automatic t_nib gf_x3(input t_nib x);
        return gf_x2(x) ^ x;
    endfunction

    function automatic t_block sub_block(input t_block v);
        return {sub_nib(v[15:12]), sub_nib(v[11:8]), sub_nib(v[7:4]), sub_nib(v[3:0])};
    endfunction

    // swap of nibbles 1 and 3
    function automatic t_block shift_block(input t_block v);
        return {v[15:12], v[3:0], v[7:4], v[11:8]};
    endfunction

    function automatic t_block mix_block(input t_block v);
        t_nib a;
        t_nib b;
        t_nib c;
        t_nib d;
        a = v[15:12];
        b = v[11:8];
        c = v[7:4];
        d = v[3:0];
        return {gf_x3(a) ^ gf_x2(b), gf_x2(a) ^ gf_x3(b),
                gf_x3(c) ^ gf_x2(d), gf_x2(c) ^ gf_x3(d)};
    endfunction

    function automatic t_block next_round_key(input t_block prev, input t_nib rcon);
        t_nib n0;
        t_nib n1;
        t_nib n2;
        t_nib n3;
        n0 = prev[15:12] ^ sub_nib(prev[3:0]) ^ rcon;
        n1 = prev[11:8] ^ n0;
        n2 = prev[7:4] ^ n1;
        n3 = prev[3:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

endpackage

`default_nettype wire

### rtl/core/maes_key_sched.sv
// Key register and round key expansion
`default_nettype none

`include "mini_aes_encrypt_defines.svh"

module maes_key_sched
    import maes_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_we,
    input  wire t_block      i_key,
    output t_round_keys      o_keys
);

    t_round_keys r_keys;
    t_round_keys n_keys;
    t_block      n_rk1;

    // expansion runs at write time so the datapath sees ready keys
    always_comb begin
        n_rk1       = next_round_key(i_key, RCON1);
        n_keys.rk0  = i_key;
        n_keys.rk1  = n_rk1;
        n_keys.rk2  = next_round_key(n_rk1, RCON2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys.rk0 <= '0;
            r_keys.rk1 <= next_round_key('0, RCON1);
            r_keys.rk2 <= next_round_key(next_round_key('0, RCON1), RCON2);
        end else if (i_we) begin
            r_keys <= n_keys;
        end
    end

    assign o_keys = r_keys;

    `MAES_ASSERT(a_key_load, i_we |=> (r_keys.rk0 == $past(i_key)),
        "round key 0 differs from written key")
    `MAES_ASSERT(a_key_chain, !i_we |=> (r_keys.rk2 == next_round_key(r_keys.rk1, RCON2)),
        "round key 2 does not follow round key 1")

endmodule

`default_nettype wire

### rtl/core/maes_stage.sv
// One pipeline register with valid and stall flow control
`default_nettype none

`include "mini_aes_encrypt_defines.svh"

module maes_stage
    import maes_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_block i_data,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_block      o_data
);

    logic   r_valid;
    t_block r_data;

    // a bubble in this stage absorbs the transfer even when downstream stalls
    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

    `MAES_ASSERT(a_hold, (r_valid && i_stall) |=> (r_valid && $stable(r_data)),
        "stalled stage lost or changed its item")

endmodule

`default_nettype wire

### rtl/core/mini_aes_encrypt.sv
// Mini AES encryption core, top level
//
//   port group                 dir  width  transfer when
//   i_valid/o_stall/i_plaintext  in   16    i_valid && !o_stall
//   o_valid/i_stall/o_ciphertext out  16    o_valid && !i_stall
//   i_cipher_key_we/i_cipher_key in   16    i_cipher_key_we
//
// One block per cycle while o_stall is low; o_valid rises once the block has
// passed the stage registers u_s1, u_s2 and u_s3.
// Stage 1: key 0 add, S-box, swap; stage 2: MixColumn, key 1 add;
// stage 3: S-box, swap, key 2 add, held in the output register.
// Round keys are expanded into registers when the key is written.
// Reset empties all stages and sets the key to zero.
// A stall holds only the full stages behind it; empty stages keep filling.
`default_nettype none

`include "mini_aes_encrypt_defines.svh"

module mini_aes_encrypt
    import maes_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cipher_key_we,
    input  wire logic [15:0]  i_cipher_key,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [15:0]  i_plaintext,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [15:0]       o_ciphertext
);

    t_round_keys keys;

    logic   s1_valid;
    logic   s1_stall;
    t_block s1_data;
    logic   s2_valid;
    logic   s2_stall;
    t_block s2_data;

    t_block d1;
    t_block d2;
    t_block d3;

    maes_key_sched u_key (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cipher_key_we),
        .i_key   (i_cipher_key),
        .o_keys  (keys)
    );

    assign d1 = shift_block(sub_block(i_plaintext ^ keys.rk0));
    assign d2 = mix_block(s1_data) ^ keys.rk1;
    assign d3 = shift_block(sub_block(s2_data)) ^ keys.rk2;

    maes_stage u_s1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (d1),
        .o_valid (s1_valid),
        .i_stall (s1_stall),
        .o_data  (s1_data)
    );

    maes_stage u_s2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_stall (s1_stall),
        .i_data  (d2),
        .o_valid (s2_valid),
        .i_stall (s2_stall),
        .o_data  (s2_data)
    );

    maes_stage u_s3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_stall (s2_stall),
        .i_data  (d3),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_ciphertext)
    );

    `MAES_ASSERT(a_full_stall, o_stall |-> (s1_valid && s2_valid && o_valid),
        "input stalled while the pipeline has a free stage")

endmodule

`default_nettype wire
